// ===== src/lmsd_pkg.sv =====
// Types and constants shared by the lane marking segment detector.
// Used by the channel interfaces and the top level; depends on nothing.
`timescale 1ns / 1ps

package lmsd_pkg;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_DARK_THR   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_THR = 8'd3;

  localparam logic [7:0]  DARK_THR_RST   = 8'd64;
  localparam logic [9:0]  MIN_GAP_RST    = 10'd2;
  localparam logic [10:0] MAX_GAP_RST    = 11'd64;
  localparam logic [7:0]  BRIGHT_THR_RST = 8'd128;

  localparam logic [17:0] SUM_MAX   = 18'h3FFFF;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  row;
    logic [9:0]  start_col;
    logic [9:0]  end_col;
    logic [15:0] segment_count;
    logic        frame_ok;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_item_t;

endpackage

// ===== src/lmsd_if.sv =====
// Valid/ready channel interfaces for pixels, results and register writes.
// Depends on lmsd_pkg for the payload types.
`timescale 1ns / 1ps

interface lmsd_in_if;
  logic              valid;
  logic              ready;
  lmsd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lmsd_out_if;
  logic               valid;
  logic               ready;
  lmsd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lmsd_cfg_if;
  logic               valid;
  logic               ready;
  lmsd_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== src/lane_marking_segment_detector.sv =====
// Lane marking segment detector: pairs dark pixels within a row into segments.
// Depends on lmsd_pkg and the channel interfaces in lmsd_if.sv.
//
// Pixels arrive in row order on in_ch, one item per pixel, with row_end and
// frame_end flags. Registers are written on cfg_ch (index 0 dark threshold,
// 1 minimum gap, 2 maximum gap, 3 brightness threshold); it is always ready.
// A pixel is held in an input register, evaluated by one stage of logic
// (a 9 by 10 bit multiply replaces the mean division) and its results are
// written to a four-entry output queue. A segment item is offered on out_ch
// once its closing pixel has passed the input register and been written to
// the queue; a pixel ending a frame adds a summary item behind it.
// Throughput is one pixel per cycle while the queue drains; a pixel is taken
// into the stage only when the queue has room for two items, so a stalled
// receiver fills the queue and then holds back in_ch without losing items.
// Synchronous active-low reset restores the register defaults, clears the
// queue and starts a new frame at row 0, column 0.
`timescale 1ns / 1ps

module lane_marking_segment_detector #(
  parameter int IMG_WIDTH  = 1024,
  parameter int IMG_HEIGHT = 1024
) (
  input  logic          clk,
  input  logic          rst_n,
  lmsd_in_if.sink       in_ch,
  lmsd_out_if.source    out_ch,
  lmsd_cfg_if.sink      cfg_ch
);
  import lmsd_pkg::*;

  localparam logic [9:0] COL_LIMIT = 10'((IMG_WIDTH > 1024) ? 1023 : IMG_WIDTH - 1);
  localparam logic [9:0] ROW_LIMIT = 10'((IMG_HEIGHT > 1024) ? 1023 : IMG_HEIGHT - 1);

  logic [7:0]  dark_thr_r;
  logic [9:0]  min_gap_r;
  logic [10:0] max_gap_r;
  logic [7:0]  bright_thr_r;

  logic        s1_vld_r;
  in_item_t    s1_r;

  logic [9:0]  column_r, column_nxt;
  logic [9:0]  row_idx_r, row_idx_nxt;
  logic        pend_vld_r, pend_vld_nxt;
  logic [9:0]  pend_col_r, pend_col_nxt;
  logic [17:0] run_sum_r, run_sum_nxt;
  logic [15:0] frame_segs_r, frame_segs_nxt;

  out_item_t   fifo_r [4];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  rd_ptr_r;
  logic [2:0]  count_r;

  logic        pop;
  logic        proc;
  logic        dark;
  logic [9:0]  gap_len;
  logic [18:0] prod;
  logic        matched;
  logic [18:0] sum_add;
  logic [15:0] segs_inc;
  out_item_t   seg_item;
  out_item_t   sum_item;
  logic [1:0]  sum_ptr;
  logic [1:0]  n_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_thr_r   <= DARK_THR_RST;
      min_gap_r    <= MIN_GAP_RST;
      max_gap_r    <= MAX_GAP_RST;
      bright_thr_r <= BRIGHT_THR_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data.index)
        REG_DARK_THR:   dark_thr_r   <= cfg_ch.data.wdata[7:0];
        REG_MIN_GAP:    min_gap_r    <= cfg_ch.data.wdata[9:0];
        REG_MAX_GAP:    max_gap_r    <= cfg_ch.data.wdata;
        REG_BRIGHT_THR: bright_thr_r <= cfg_ch.data.wdata[7:0];
        default: ;
      endcase
    end
  end

  assign pop          = out_ch.valid && out_ch.ready;
  assign proc         = s1_vld_r && ((count_r - {2'b00, pop}) <= 3'd2);
  assign in_ch.ready  = !s1_vld_r || proc;
  assign out_ch.valid = (count_r != 3'd0);
  assign out_ch.data  = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_r <= in_ch.data;
    end
  end

  always_comb begin
    dark     = s1_r.pixel < dark_thr_r;
    gap_len  = column_r - pend_col_r;
    prod     = ({1'b0, bright_thr_r} + 9'd1) * gap_len;
    matched  = dark && pend_vld_r && (column_r >= pend_col_r) && (gap_len != 10'd0) &&
               (gap_len > min_gap_r) && ({1'b0, gap_len} < max_gap_r) &&
               ({1'b0, run_sum_r} >= prod);
    sum_add  = {1'b0, run_sum_r} + {11'd0, s1_r.pixel};
    segs_inc = (matched && (frame_segs_r != COUNT_MAX)) ? frame_segs_r + 16'd1
                                                         : frame_segs_r;

    column_nxt     = column_r;
    row_idx_nxt    = row_idx_r;
    pend_vld_nxt   = pend_vld_r;
    pend_col_nxt   = pend_col_r;
    run_sum_nxt    = run_sum_r;
    frame_segs_nxt = segs_inc;

    if (matched) begin
      pend_vld_nxt = 1'b0;
      run_sum_nxt  = '0;
    end else if (dark) begin
      pend_vld_nxt = 1'b1;
      pend_col_nxt = column_r;
      run_sum_nxt  = {10'd0, s1_r.pixel};
    end else if (pend_vld_r) begin
      run_sum_nxt = sum_add[18] ? SUM_MAX : sum_add[17:0];
    end

    if (s1_r.frame_end) begin
      frame_segs_nxt = '0;
      row_idx_nxt    = '0;
      column_nxt     = '0;
      pend_vld_nxt   = 1'b0;
      run_sum_nxt    = '0;
    end else if (s1_r.row_end) begin
      column_nxt   = '0;
      row_idx_nxt  = (row_idx_r < ROW_LIMIT) ? row_idx_r + 10'd1 : row_idx_r;
      pend_vld_nxt = 1'b0;
      run_sum_nxt  = '0;
    end else if (column_r < COL_LIMIT) begin
      column_nxt = column_r + 10'd1;
    end

    seg_item               = '0;
    seg_item.kind          = KIND_SEGMENT;
    seg_item.row           = row_idx_r;
    seg_item.start_col     = pend_col_r;
    seg_item.end_col       = column_r;
    seg_item.last          = !s1_r.frame_end;

    sum_item               = '0;
    sum_item.kind          = KIND_SUMMARY;
    sum_item.segment_count = segs_inc;
    sum_item.frame_ok      = segs_inc >= 16'd2;
    sum_item.last          = 1'b1;

    sum_ptr = wr_ptr_r + {1'b0, matched};
    n_res   = {1'b0, matched} + {1'b0, s1_r.frame_end};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r     <= '0;
      row_idx_r    <= '0;
      pend_vld_r   <= 1'b0;
      pend_col_r   <= '0;
      run_sum_r    <= '0;
      frame_segs_r <= '0;
    end else if (proc) begin
      column_r     <= column_nxt;
      row_idx_r    <= row_idx_nxt;
      pend_vld_r   <= pend_vld_nxt;
      pend_col_r   <= pend_col_nxt;
      run_sum_r    <= run_sum_nxt;
      frame_segs_r <= frame_segs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && matched) begin
      fifo_r[wr_ptr_r] <= seg_item;
    end
    if (proc && s1_r.frame_end) begin
      fifo_r[sum_ptr] <= sum_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (proc) begin
        wr_ptr_r <= wr_ptr_r + n_res;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_r + (proc ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 3'd4)
    else $error("result queue overflow");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.data.kind == KIND_SUMMARY) |-> out_ch.data.last)
    else $error("summary item without last");

  a_segment_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.data.kind == KIND_SEGMENT) |->
      (out_ch.data.segment_count == 16'd0) && !out_ch.data.frame_ok)
    else $error("segment item carries summary fields");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    proc && s1_r.frame_end |=> (frame_segs_r == 16'd0) && (row_idx_r == 10'd0) &&
      (column_r == 10'd0) && !pend_vld_r)
    else $error("frame state not cleared after frame end");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the lane marking segment detector.
// Needs lmsd_pkg, the channel interfaces in lmsd_if.sv and the detector top level.
// A directed table and then random frames are run through the block against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import lmsd_pkg::*;

  localparam int IMG_W         = 1024;
  localparam int IMG_H         = 1024;
  localparam int COL_MAX       = (IMG_W > 1024) ? 1023 : IMG_W - 1;
  localparam int ROW_MAX       = (IMG_H > 1024) ? 1023 : IMG_H - 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int WATCHDOG_MAX  = 4000;
  localparam int PHASE_PIXELS  = 65;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'hA5;

  typedef struct packed {
    in_item_t    px;
    logic        typed;
    logic [1:0]  cnt;
    out_item_t   e0;
    out_item_t   e1;
  } dir_row_t;

  logic clk;
  logic rst_n;

  lmsd_in_if  in_ch ();
  lmsd_out_if out_ch ();
  lmsd_cfg_if cfg_ch ();

  lane_marking_segment_detector i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor copy of the registers and the scan state.
  logic [7:0]  dark_thr   = DARK_THR_RST;
  logic [9:0]  min_gap    = MIN_GAP_RST;
  logic [10:0] max_gap    = MAX_GAP_RST;
  logic [7:0]  bright_thr = BRIGHT_THR_RST;
  logic [9:0]  px_col     = '0;
  logic [9:0]  px_row     = '0;
  logic        open_valid = 1'b0;
  logic [9:0]  open_col   = '0;
  int          open_sum   = 0;
  logic [15:0] frame_marks = '0;

  out_item_t due_results[$];
  dir_row_t  dir_rows[$];
  int        errors      = 0;
  int        pixels_sent = 0;
  int        burst_left  = 0;
  int        idle_cycles = 0;
  bit        hold_req    = 1'b0;
  bit        hold_done   = 1'b0;
  bit        draining    = 1'b0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic in_item_t pxl(input logic [7:0] p, input logic re, input logic fe);
    in_item_t v;
    v.pixel = p;
    v.row_end = re;
    v.frame_end = fe;
    return v;
  endfunction

  function automatic out_item_t seg(input logic [9:0] r, s, e, input logic l);
    out_item_t o;
    o = '0;
    o.kind = KIND_SEGMENT;
    o.row = r;
    o.start_col = s;
    o.end_col = e;
    o.last = l;
    return o;
  endfunction

  function automatic out_item_t summ(input logic [15:0] c, input logic ok, input logic l);
    out_item_t o;
    o = '0;
    o.kind = KIND_SUMMARY;
    o.segment_count = c;
    o.frame_ok = ok;
    o.last = l;
    return o;
  endfunction

  function automatic logic [7:0] dark_pixel();
    if (dark_thr == 0 || $urandom_range(0, 9) == 0) return dark_thr;
    return 8'($urandom_range(0, dark_thr - 1));
  endfunction

  function automatic logic [7:0] bright_pixel();
    if (bright_thr == 8'hFF || $urandom_range(0, 9) == 0) return bright_thr;
    return 8'($urandom_range(bright_thr + 1, 255));
  endfunction

  task automatic detect_segments(input in_item_t px, input bit keep);
    int gap_len;
    bit closed;
    closed = 1'b0;
    if (px.pixel < dark_thr) begin
      if (open_valid) begin
        gap_len = int'(px_col) - int'(open_col);
        if (gap_len > 0 && gap_len > int'(min_gap) && gap_len < int'(max_gap)) begin
          closed = (open_sum / gap_len) > int'(bright_thr);
        end
      end
      if (closed) begin
        if (keep) due_results = {due_results, seg(px_row, open_col, px_col, !px.frame_end)};
        if (frame_marks < COUNT_MAX) frame_marks++;
        open_valid = 1'b0;
        open_sum = 0;
      end else begin
        open_valid = 1'b1;
        open_col = px_col;
        open_sum = int'(px.pixel);
      end
    end else if (open_valid) begin
      open_sum += int'(px.pixel);
      if (open_sum > int'(SUM_MAX)) open_sum = int'(SUM_MAX);
    end

    if (px.frame_end) begin
      if (keep) due_results = {due_results, summ(frame_marks, frame_marks >= 2, 1'b1)};
      frame_marks = '0;
      px_row = '0;
      px_col = '0;
      open_valid = 1'b0;
      open_sum = 0;
    end else if (px.row_end) begin
      px_col = '0;
      if (px_row < ROW_MAX) px_row++;
      open_valid = 1'b0;
      open_sum = 0;
    end else if (px_col < COL_MAX) begin
      px_col++;
    end
  endtask

  task automatic push_pixel(input in_item_t px, input logic typed, input logic [1:0] cnt,
                            input out_item_t e0, input out_item_t e1);
    int gap;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pixels_sent++;
    detect_segments(px, !typed);
    if (typed) begin
      if (cnt > 0) due_results = {due_results, e0};
      if (cnt > 1) due_results = {due_results, e1};
    end
  endtask

  task automatic send(input in_item_t px);
    push_pixel(px, 1'b0, 2'd0, '0, '0);
  endtask

  task automatic program_regs(input logic [10:0] d, mn, mx, br, input bit spare);
    cfg_item_t w[5];
    int nw;
    w[0].index = REG_DARK_THR;   w[0].wdata = d;
    w[1].index = REG_MIN_GAP;    w[1].wdata = mn;
    w[2].index = REG_MAX_GAP;    w[2].wdata = mx;
    w[3].index = REG_BRIGHT_THR; w[3].wdata = br;
    w[4] = '0;
    nw = 4;
    if (spare) begin
      w[4].index = REG_SPARE;
      w[4].wdata = 11'($urandom_range(0, 2047));
      nw = 5;
    end
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < nw; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.data <= w[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      case (w[i].index)
        REG_DARK_THR:   dark_thr = w[i].wdata[7:0];
        REG_MIN_GAP:    min_gap = w[i].wdata[9:0];
        REG_MAX_GAP:    max_gap = w[i].wdata;
        REG_BRIGHT_THR: bright_thr = w[i].wdata[7:0];
        default: ;
      endcase
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic gen_row(input int width, input bit closes_frame);
    logic [7:0] line[$];
    int run;
    in_item_t px;
    while (line.size() < width) begin
      if ($urandom_range(0, 9) < 6 && width - line.size() >= 3) begin
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 70) : $urandom_range(0, 12);
        if (run > width - line.size() - 2) run = width - line.size() - 2;
        line = {line, dark_pixel()};
        repeat (run) line = {line, bright_pixel()};
        line = {line, dark_pixel()};
      end else begin
        line = {line, 8'($urandom_range(0, 255))};
      end
    end
    foreach (line[i]) begin
      px = pxl(line[i], i == width - 1, 1'b0);
      if (i == width - 1 && closes_frame) begin
        px.frame_end = 1'b1;
        px.row_end = 1'($urandom_range(0, 1));
      end else if ($urandom_range(0, 299) == 0) begin
        px.frame_end = 1'b1;
      end
      send(px);
    end
  endtask

  task automatic gen_frame();
    int rows;
    int w;
    rows = $urandom_range(1, 4);
    for (int r = 0; r < rows; r++) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(4, 40);
      gen_row(w, r == rows - 1);
    end
  endtask

  task automatic add_row(input in_item_t px, input logic typed, input logic [1:0] cnt,
                         input out_item_t e0, input out_item_t e1);
    dir_row_t r;
    r.px = px;
    r.typed = typed;
    r.cnt = cnt;
    r.e0 = e0;
    r.e1 = e1;
    dir_rows = {dir_rows, r};
  endtask

  task automatic add_free(input in_item_t px);
    add_row(px, 1'b0, 2'd0, '0, '0);
  endtask

  task automatic build_directed();
    add_free(pxl(8'd10, 1'b0, 1'b0));
    add_free(pxl(8'd255, 1'b0, 1'b0));
    add_free(pxl(8'd255, 1'b0, 1'b0));
    add_free(pxl(8'd255, 1'b0, 1'b0));
    add_row(pxl(8'd0, 1'b0, 1'b0), 1'b1, 2'd1, seg(10'd0, 10'd0, 10'd4, 1'b1), '0);
    add_free(pxl(8'd255, 1'b1, 1'b0));
    add_free(pxl(8'd63, 1'b0, 1'b0));
    add_free(pxl(8'd200, 1'b0, 1'b0));
    add_free(pxl(8'd200, 1'b0, 1'b0));
    add_free(pxl(8'd64, 1'b0, 1'b0));
    add_row(pxl(8'd0, 1'b0, 1'b1), 1'b1, 2'd2, seg(10'd1, 10'd0, 10'd4, 1'b0),
            summ(16'd2, 1'b1, 1'b1));
    add_row(pxl(8'd255, 1'b1, 1'b1), 1'b1, 2'd1, summ(16'd0, 1'b0, 1'b1), '0);
    add_free(pxl(8'd0, 1'b0, 1'b0));
    add_free(pxl(8'd1, 1'b0, 1'b0));
    add_free(pxl(8'd255, 1'b0, 1'b0));
    add_free(pxl(8'd254, 1'b0, 1'b0));
    add_row(pxl(8'd2, 1'b0, 1'b0), 1'b1, 2'd1, seg(10'd0, 10'd1, 10'd4, 1'b1), '0);
    // The mean inside the next pair equals the brightness threshold exactly.
    add_free(pxl(8'd63, 1'b0, 1'b0));
    add_free(pxl(8'd160, 1'b0, 1'b0));
    add_free(pxl(8'd161, 1'b0, 1'b0));
    add_free(pxl(8'd40, 1'b1, 1'b0));
    add_row(pxl(8'd128, 1'b0, 1'b1), 1'b1, 2'd1, summ(16'd1, 1'b0, 1'b1), '0);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    out_item_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, got kind %0d row %0d cols %0d..%0d",
                 $time, got.kind, got.row, got.start_col, got.end_col);
      end else begin
        want = due_results.pop_front();
        check_field("kind", want.kind, got.kind);
        check_field("row", want.row, got.row);
        check_field("start_col", want.start_col, got.start_col);
        check_field("end_col", want.end_col, got.end_col);
        check_field("segment_count", want.segment_count, got.segment_count);
        check_field("frame_ok", want.frame_ok, got.frame_ok);
        check_field("last", want.last, got.last);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("lane_marking_segment_detector test failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int mode;
    int len;
    int k;
    out_ch.ready = 1'b0;
    k = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        @(posedge clk);
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = $urandom_range(0, 3);
        len = $urandom_range(5, 60);
        repeat (len) begin
          @(posedge clk);
          k++;
          if (draining) begin
            out_ch.ready <= 1'b1;
          end else begin
            case (mode)
              0: out_ch.ready <= 1'b1;
              1: out_ch.ready <= 1'($urandom_range(0, 1));
              2: out_ch.ready <= (k % 3 != 0);
              default: out_ch.ready <= 1'b0;
            endcase
          end
        end
      end
    end
  end

  initial begin : stimulus
    int base;
    logic [7:0] d;
    logic [9:0] mn;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    build_directed();
    foreach (dir_rows[i]) begin
      push_pixel(dir_rows[i].px, dir_rows[i].typed, dir_rows[i].cnt, dir_rows[i].e0,
                 dir_rows[i].e1);
    end

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: program_regs(DARK_THR_RST, MIN_GAP_RST, MAX_GAP_RST, BRIGHT_THR_RST, 1'b1);
        1: program_regs(11'd255, 11'd0, 11'd1024, 11'd0, 1'b0);
        2: program_regs(11'd0, 11'd1023, 11'd2047, 11'd255, 1'b0);
        3: program_regs(11'($urandom_range(1, 255)), 11'd0, 11'd1,
                        11'($urandom_range(0, 255)), 1'b0);
        default: begin
          d = 8'($urandom_range(30, 220));
          mn = 10'($urandom_range(0, 6));
          program_regs(d, mn,
                       ($urandom_range(0, 4) == 0) ? 11'($urandom_range(1025, 2047))
                                                   : 11'(mn + $urandom_range(2, 60)),
                       11'($urandom_range(60, 230)), 1'b1);
        end
      endcase
      if (p == 4) hold_req = 1'b1;
      base = pixels_sent;
      while (pixels_sent - base < PHASE_PIXELS) gen_frame();
    end

    in_ch.valid <= 1'b0;
    draining = 1'b1;
    while (due_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("lane_marking_segment_detector test passed");
    end else begin
      $display("lane_marking_segment_detector test failed");
    end
    $finish;
  end

endmodule
